@@ hdl/pfa_pkg.sv @@
// shared constants, codes and beat types of the paged frame allocator
package pfa_pkg;

    localparam int NUM_FRAMES = 256;
    localparam int MAX_PROCS  = 16;
    localparam int MAX_PAGES  = 64;

    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int FREE_W  = $clog2(NUM_FRAMES + 1);
    localparam int SLOT_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int PAGE_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W   = $clog2(MAX_PAGES + 2);
    localparam int TBL_AW  = SLOT_W + PAGE_W;
    localparam int TBL_D   = MAX_PROCS * (2 ** PAGE_W);

    localparam int PS_W    = 17;
    localparam int MEM_W   = 25;
    localparam int CFG_W   = 25;
    localparam int CFG_AW  = 1;
    localparam int SIZE_W  = 32;
    localparam int ACC_W   = 33;

    localparam logic [PS_W-1:0]  PS_RESET  = PS_W'(32);
    localparam logic [MEM_W-1:0] MEM_RESET = MEM_W'(4096);

    typedef enum logic [CFG_AW-1:0] {
        REG_PAGE_SIZE = 1'b0,
        REG_MEM_SIZE  = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        OP_CREATE    = 2'd0,
        OP_RESIZE    = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_KILL      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NOMEM  = 3'd1,
        ST_NOPAGE = 3'd2,
        ST_NOPROC = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISP,
        S_DIV,
        S_GROW_RD,
        S_GROW_WR,
        S_SHR_RD,
        S_SHR_WR,
        S_TR_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        op;
        logic [15:0]       pid;
        logic [SIZE_W-1:0] req_bytes;
        logic [31:0]       vpage;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] frame;
    } t_rsp;

endpackage

@@ hdl/pfa_ram.sv @@
// generic single write, single read ram with registered read
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hdl/paged_frame_allocator.sv @@
// paged frame allocator: free frame fifo, process slots and page tables
// create, translate miss, unknown pid end in dispatch; translate hit adds a table read
// resize: page count by the size counter, then a read and a write per frame moved
// kill: a read and a write per frame returned; one request at a time, busy until its result
// reset or any config write runs a sweep of the whole frame fifo, busy high
// the result is a single-cycle strobe, the receiver cannot stall
module paged_frame_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  pfa_pkg::t_req              i_req,
    output logic                       o_done,
    output pfa_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_we,
    input  logic [pfa_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [pfa_pkg::CFG_W-1:0]  i_cfg_wdata
);

    pfa_pkg::t_state r_state, n_state;

    logic [pfa_pkg::PS_W-1:0]    r_page_size;
    logic [pfa_pkg::MEM_W-1:0]   r_mem_size;
    pfa_pkg::t_req               r_req;
    logic                        r_hit;
    logic [pfa_pkg::SLOT_W-1:0]  r_slot;
    logic [pfa_pkg::CNT_W-1:0]   r_cnt,   n_cnt;
    logic [pfa_pkg::CNT_W-1:0]   r_pages, n_pages;
    logic [pfa_pkg::ACC_W-1:0]   r_acc,   n_acc;
    logic [pfa_pkg::FRAME_W-1:0] r_idx;
    logic [pfa_pkg::FRAME_W-1:0] r_head,  n_head;
    logic [pfa_pkg::FRAME_W-1:0] r_tail,  n_tail;
    logic [pfa_pkg::FREE_W-1:0]  r_free,  n_free;
    logic [pfa_pkg::MAX_PROCS-1:0] r_valid, n_valid;
    logic [15:0]                 r_pid  [pfa_pkg::MAX_PROCS];
    logic [pfa_pkg::CNT_W-1:0]   r_pcnt [pfa_pkg::MAX_PROCS];
    logic                        r_done,  n_done;
    pfa_pkg::t_rsp               r_rsp,   n_rsp;

    logic                        hit;
    logic [pfa_pkg::SLOT_W-1:0]  hit_slot;
    logic                        slot_free;
    logic [pfa_pkg::SLOT_W-1:0]  free_slot;
    logic [pfa_pkg::PS_W-1:0]    eff_ps;
    logic                        div_more;
    logic                        too_big;
    logic [pfa_pkg::FREE_W-1:0]  need;
    logic                        grow_last;
    logic                        shr_last;
    logic                        tr_ok;
    logic                        pid_we;
    logic                        pcnt_we;
    logic [pfa_pkg::CNT_W-1:0]   pcnt_wdata;

    logic                        q_we;
    logic [pfa_pkg::FRAME_W-1:0] q_waddr, q_wdata, q_rdata;
    logic                        t_we;
    logic [pfa_pkg::TBL_AW-1:0]  t_waddr, t_raddr;
    logic [pfa_pkg::FRAME_W-1:0] t_rdata;
    logic [pfa_pkg::CNT_W-1:0]   cnt_dec;

    pfa_ram #(.WIDTH(pfa_pkg::FRAME_W), .DEPTH(pfa_pkg::NUM_FRAMES)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    pfa_ram #(.WIDTH(pfa_pkg::FRAME_W), .DEPTH(pfa_pkg::TBL_D)) u_table (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (q_rdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    always_comb begin
        hit       = 1'b0;
        hit_slot  = '0;
        slot_free = 1'b0;
        free_slot = '0;
        for (int i = pfa_pkg::MAX_PROCS - 1; i >= 0; i--) begin
            if (r_valid[i] && r_pid[i] == i_req.pid) begin
                hit      = 1'b1;
                hit_slot = pfa_pkg::SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                slot_free = 1'b1;
                free_slot = pfa_pkg::SLOT_W'(i);
            end
        end
    end

    assign eff_ps    = (r_page_size == '0) ? pfa_pkg::PS_W'(1) : r_page_size;
    assign div_more  = (r_acc < {1'b0, r_req.req_bytes})
                       && (r_pages <= pfa_pkg::CNT_W'(pfa_pkg::MAX_PAGES));
    assign too_big   = r_pages > pfa_pkg::CNT_W'(pfa_pkg::MAX_PAGES);
    assign need      = pfa_pkg::FREE_W'(r_pages) - pfa_pkg::FREE_W'(r_cnt);
    assign cnt_dec   = r_cnt - pfa_pkg::CNT_W'(1);
    assign grow_last = (r_cnt + pfa_pkg::CNT_W'(1)) == r_pages;
    assign shr_last  = r_cnt == r_pages;
    assign tr_ok     = r_req.vpage < 32'(r_pcnt[r_slot]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfa_pkg::S_INIT: begin
                if (r_idx == pfa_pkg::FRAME_W'(pfa_pkg::NUM_FRAMES - 1)) begin
                    n_state = pfa_pkg::S_IDLE;
                end
            end
            pfa_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = pfa_pkg::S_DISP;
                end
            end
            pfa_pkg::S_DISP: begin
                n_state = pfa_pkg::S_IDLE;
                if (r_req.op != pfa_pkg::OP_CREATE && r_hit) begin
                    case (r_req.op)
                        pfa_pkg::OP_RESIZE: begin
                            if (r_req.req_bytes <= 32'(r_mem_size)) begin
                                n_state = pfa_pkg::S_DIV;
                            end
                        end
                        pfa_pkg::OP_TRANSLATE: begin
                            if (tr_ok) begin
                                n_state = pfa_pkg::S_TR_DONE;
                            end
                        end
                        pfa_pkg::OP_KILL: begin
                            if (r_pcnt[r_slot] != '0) begin
                                n_state = pfa_pkg::S_SHR_RD;
                            end
                        end
                        default: n_state = pfa_pkg::S_IDLE;
                    endcase
                end
            end
            pfa_pkg::S_DIV: begin
                if (!div_more) begin
                    n_state = pfa_pkg::S_IDLE;
                    if (!too_big) begin
                        if (r_pages > r_cnt && r_free >= need) begin
                            n_state = pfa_pkg::S_GROW_RD;
                        end else if (r_pages < r_cnt) begin
                            n_state = pfa_pkg::S_SHR_RD;
                        end
                    end
                end
            end
            pfa_pkg::S_GROW_RD: n_state = pfa_pkg::S_GROW_WR;
            pfa_pkg::S_GROW_WR: n_state = grow_last ? pfa_pkg::S_IDLE : pfa_pkg::S_GROW_RD;
            pfa_pkg::S_SHR_RD:  n_state = pfa_pkg::S_SHR_WR;
            pfa_pkg::S_SHR_WR:  n_state = shr_last ? pfa_pkg::S_IDLE : pfa_pkg::S_SHR_RD;
            pfa_pkg::S_TR_DONE: n_state = pfa_pkg::S_IDLE;
            default:            n_state = pfa_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cnt      = r_cnt;
        n_pages    = r_pages;
        n_acc      = r_acc;
        n_head     = r_head;
        n_tail     = r_tail;
        n_free     = r_free;
        n_valid    = r_valid;
        n_done     = 1'b0;
        n_rsp      = '0;
        pid_we     = 1'b0;
        pcnt_we    = 1'b0;
        pcnt_wdata = '0;
        q_we       = 1'b0;
        q_waddr    = r_tail;
        q_wdata    = t_rdata;
        t_we       = 1'b0;
        t_waddr    = {r_slot, r_cnt[pfa_pkg::PAGE_W-1:0]};
        t_raddr    = {r_slot, cnt_dec[pfa_pkg::PAGE_W-1:0]};
        case (r_state)
            pfa_pkg::S_INIT: begin
                q_we    = 1'b1;
                q_waddr = r_idx;
                q_wdata = r_idx;
                n_acc   = r_acc + pfa_pkg::ACC_W'(eff_ps);
                if (r_acc < pfa_pkg::ACC_W'(r_mem_size)) begin
                    n_free = r_free + pfa_pkg::FREE_W'(1);
                end
                n_tail  = n_free[pfa_pkg::FRAME_W-1:0];
            end
            pfa_pkg::S_DISP: begin
                n_done  = 1'b1;
                n_cnt   = r_pcnt[r_slot];
                n_pages = '0;
                n_acc   = '0;
                t_raddr = {r_slot, r_req.vpage[pfa_pkg::PAGE_W-1:0]};
                if (r_req.op == pfa_pkg::OP_CREATE) begin
                    if (r_hit) begin
                        n_rsp.status = pfa_pkg::ST_OK;
                    end else if (slot_free) begin
                        n_rsp.status = pfa_pkg::ST_OK;
                        n_valid[free_slot] = 1'b1;
                        pid_we  = 1'b1;
                        pcnt_we = 1'b1;
                    end else begin
                        n_rsp.status = pfa_pkg::ST_FULL;
                    end
                end else if (!r_hit) begin
                    n_rsp.status = pfa_pkg::ST_NOPROC;
                end else begin
                    case (r_req.op)
                        pfa_pkg::OP_RESIZE: begin
                            if (r_req.req_bytes <= 32'(r_mem_size)) begin
                                n_done = 1'b0;
                            end else begin
                                n_rsp.status = pfa_pkg::ST_NOMEM;
                            end
                        end
                        pfa_pkg::OP_TRANSLATE: begin
                            if (tr_ok) begin
                                n_done = 1'b0;
                            end else begin
                                n_rsp.status = pfa_pkg::ST_NOPAGE;
                            end
                        end
                        pfa_pkg::OP_KILL: begin
                            if (r_pcnt[r_slot] != '0) begin
                                n_done = 1'b0;
                            end else begin
                                n_valid[r_slot] = 1'b0;
                            end
                        end
                        default: n_rsp.status = pfa_pkg::ST_OK;
                    endcase
                end
            end
            pfa_pkg::S_DIV: begin
                if (div_more) begin
                    n_pages = r_pages + pfa_pkg::CNT_W'(1);
                    n_acc   = r_acc + pfa_pkg::ACC_W'(eff_ps);
                end else if (too_big || (r_pages > r_cnt && r_free < need)) begin
                    n_done       = 1'b1;
                    n_rsp.status = pfa_pkg::ST_NOMEM;
                end else if (r_pages == r_cnt) begin
                    n_done = 1'b1;
                end
            end
            pfa_pkg::S_GROW_RD: begin
                n_head = r_head + pfa_pkg::FRAME_W'(1);
                n_free = r_free - pfa_pkg::FREE_W'(1);
            end
            pfa_pkg::S_GROW_WR: begin
                t_we  = 1'b1;
                n_cnt = r_cnt + pfa_pkg::CNT_W'(1);
                if (grow_last) begin
                    pcnt_we    = 1'b1;
                    pcnt_wdata = n_cnt;
                    n_done     = 1'b1;
                end
            end
            pfa_pkg::S_SHR_RD: begin
                n_cnt = cnt_dec;
            end
            pfa_pkg::S_SHR_WR: begin
                if (r_free < pfa_pkg::FREE_W'(pfa_pkg::NUM_FRAMES)) begin
                    q_we   = 1'b1;
                    n_tail = r_tail + pfa_pkg::FRAME_W'(1);
                    n_free = r_free + pfa_pkg::FREE_W'(1);
                end
                if (shr_last) begin
                    pcnt_we    = 1'b1;
                    pcnt_wdata = r_cnt;
                    n_done     = 1'b1;
                    if (r_req.op == pfa_pkg::OP_KILL) begin
                        n_valid[r_slot] = 1'b0;
                    end
                end
            end
            pfa_pkg::S_TR_DONE: begin
                n_done      = 1'b1;
                n_rsp.frame = 8'(t_rdata);
            end
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfa_pkg::S_INIT;
            r_page_size <= pfa_pkg::PS_RESET;
            r_mem_size  <= pfa_pkg::MEM_RESET;
            r_idx       <= '0;
            r_acc       <= '0;
            r_free      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_valid     <= '0;
            r_done      <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pfa_pkg::REG_PAGE_SIZE) begin
                r_page_size <= i_cfg_wdata[pfa_pkg::PS_W-1:0];
            end else begin
                r_mem_size <= i_cfg_wdata[pfa_pkg::MEM_W-1:0];
            end
            r_state <= pfa_pkg::S_INIT;
            r_idx   <= '0;
            r_acc   <= '0;
            r_free  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= r_idx + pfa_pkg::FRAME_W'(1);
            r_acc   <= n_acc;
            r_free  <= n_free;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_valid <= n_valid;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_pages <= n_pages;
        r_rsp   <= n_rsp;
        if (r_state == pfa_pkg::S_IDLE && i_start) begin
            r_req  <= i_req;
            r_hit  <= hit;
            r_slot <= hit_slot;
        end
        if (pid_we) begin
            r_pid[free_slot] <= r_req.pid;
        end
        if (pid_we) begin
            r_pcnt[free_slot] <= '0;
        end else if (pcnt_we) begin
            r_pcnt[r_slot] <= pcnt_wdata;
        end
    end

    assign o_busy = r_state != pfa_pkg::S_IDLE;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

@@ hdl/pfa_checker.sv @@
// port level checks of the paged frame allocator and their bind
module pfa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          o_busy,
    input logic          o_done,
    input pfa_pkg::t_rsp o_rsp
);

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.status == pfa_pkg::ST_OK || o_rsp.status == pfa_pkg::ST_NOMEM
                 || o_rsp.status == pfa_pkg::ST_NOPAGE || o_rsp.status == pfa_pkg::ST_NOPROC
                 || o_rsp.status == pfa_pkg::ST_FULL))
        else $error("result status out of range");

    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != pfa_pkg::ST_OK) |-> o_rsp.frame == '0)
        else $error("frame nonzero on failed request");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted beat did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results for one beat");

endmodule

bind paged_frame_allocator pfa_checker u_pfa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
